@@ rtl/irn_pkg.sv @@
// ----------------------------------------------------------------------------
// irn_pkg
// Shared types and constants for the nearest-neighbour image rotator.
// ----------------------------------------------------------------------------
package irn_pkg;

	// field widths fixed by the interface
	localparam int COORD_W   = 8;
	localparam int PIX_W     = 8;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 1;
	localparam int ADDR_W    = 2 * COORD_W;
	localparam int STORE_DIM = 256;

	// input word commands
	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_FETCH = 1'b1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_COS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_SIN = 1'b1;

	// controller to datapath commands
	typedef struct packed {
		logic load_we;   // load word accepted
		logic take;      // fetch word accepted, capture coordinates
		logic mul_en;    // register rotation products
		logic sum_en;    // register source address and bounds flag
		logic rd_en;     // read frame store
		logic out_load;  // move read result into output register
	} irn_ctl_t;

endpackage

@@ rtl/image_rotate_nearest.sv @@
// ----------------------------------------------------------------------------
// image_rotate_nearest
// Rotates a grayscale frame about its centre by inverse mapping with
// nearest-neighbour sampling.
//
//   channel  direction  handshake           payload
//   in       input      in_valid/in_stall   cmd, row, col, pixel_in
//   out      output     out_valid/out_stall out_row, out_col, pixel_out, in_range
//   cfg      input      cfg_we              cfg_index, cfg_data
//
// A load word needs no sequencer step. A fetch word steps
// the sequencer through capture, multiply, sum and bounds check, frame store
// read and output. The single-port frame store serialises fetches through this
// sequence. in_stall is high while a fetch is in flight; a finished word waits
// in the output register while the next input word is taken. Reset clears
// control, sets cosine to one and sine to zero; the frame store is not cleared.
// ----------------------------------------------------------------------------
module image_rotate_nearest #(
	parameter int WIDTH     = 256,
	parameter int HEIGHT    = 256,
	parameter int FRAC_BITS = 14
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          cmd,
	input  logic [irn_pkg::COORD_W-1:0]   row,
	input  logic [irn_pkg::COORD_W-1:0]   col,
	input  logic [irn_pkg::PIX_W-1:0]     pixel_in,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [irn_pkg::COORD_W-1:0]   out_row,
	output logic [irn_pkg::COORD_W-1:0]   out_col,
	output logic [irn_pkg::PIX_W-1:0]     pixel_out,
	output logic                          in_range,
	input  logic                          cfg_we,
	input  logic [irn_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [irn_pkg::CFG_W-1:0]     cfg_data
);

	irn_pkg::irn_ctl_t ctl;

	// sequencer
	irn_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.cmd       (cmd),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.ctl       (ctl)
	);

	// datapath
	irn_dp #(
		.WIDTH     (WIDTH),
		.HEIGHT    (HEIGHT),
		.FRAC_BITS (FRAC_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.row       (row),
		.col       (col),
		.pixel_in  (pixel_in),
		.out_row   (out_row),
		.out_col   (out_col),
		.pixel_out (pixel_out),
		.in_range  (in_range)
	);

endmodule

@@ rtl/irn_ram.sv @@
// ----------------------------------------------------------------------------
// irn_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module irn_ram #(
	parameter int DATA_W = 8,
	parameter int DEPTH  = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [DATA_W-1:0]        wdata,
	output logic [DATA_W-1:0]        rdata
);

	logic [DATA_W-1:0] mem [DEPTH];

	// write or registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

@@ rtl/irn_ctrl.sv @@
// ----------------------------------------------------------------------------
// irn_ctrl
// Sequencer for one fetch at a time and output word valid flag.
// ----------------------------------------------------------------------------
module irn_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            cmd,
	output logic            in_stall,
	output logic            out_valid,
	input  logic            out_stall,
	output irn_pkg::irn_ctl_t ctl
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_SUM,
		ST_READ,
		ST_PUSH
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   accept;
	logic   out_free;

	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	// command decode
	always_comb begin
		ctl          = '0;
		ctl.load_we  = accept && (cmd == irn_pkg::CMD_LOAD);
		ctl.take     = accept && (cmd == irn_pkg::CMD_FETCH);
		ctl.mul_en   = (state_q == ST_MUL);
		ctl.sum_en   = (state_q == ST_SUM);
		ctl.rd_en    = (state_q == ST_READ);
		ctl.out_load = (state_q == ST_PUSH) && out_free;
	end

	// state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept && (cmd == irn_pkg::CMD_FETCH)) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL:  state_q <= ST_SUM;
				ST_SUM:  state_q <= ST_READ;
				ST_READ: state_q <= ST_PUSH;
				ST_PUSH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (ctl.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

@@ rtl/irn_dp.sv @@
// ----------------------------------------------------------------------------
// irn_dp
// Datapath: angle registers, rotation multipliers, bounds check, frame store
// and output word register.
// ----------------------------------------------------------------------------
module irn_dp #(
	parameter int WIDTH     = 256,
	parameter int HEIGHT    = 256,
	parameter int FRAC_BITS = 14
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  irn_pkg::irn_ctl_t                   ctl,
	input  logic                                cfg_we,
	input  logic [irn_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [irn_pkg::CFG_W-1:0]           cfg_data,
	input  logic [irn_pkg::COORD_W-1:0]         row,
	input  logic [irn_pkg::COORD_W-1:0]         col,
	input  logic [irn_pkg::PIX_W-1:0]           pixel_in,
	output logic [irn_pkg::COORD_W-1:0]         out_row,
	output logic [irn_pkg::COORD_W-1:0]         out_col,
	output logic [irn_pkg::PIX_W-1:0]           pixel_out,
	output logic                                in_range
);

	localparam int CW_B   = irn_pkg::COORD_W;
	localparam int MAXDIM = (WIDTH > HEIGHT) ? WIDTH : HEIGHT;
	localparam int DIM_B  = ($clog2(MAXDIM) > CW_B) ? $clog2(MAXDIM) : CW_B;
	localparam int CW     = DIM_B + 2;
	localparam int PW     = irn_pkg::CFG_W + CW;
	localparam int ACC_A  = PW + 3;
	localparam int ACC_B  = DIM_B + FRAC_BITS + 3;
	localparam int ACC_W  = (ACC_A > ACC_B) ? ACC_A : ACC_B;
	localparam int EFF_W  = (WIDTH < irn_pkg::STORE_DIM) ? WIDTH : irn_pkg::STORE_DIM;
	localparam int EFF_H  = (HEIGHT < irn_pkg::STORE_DIM) ? HEIGHT : irn_pkg::STORE_DIM;
	localparam int HALF_W = WIDTH / 2;
	localparam int HALF_H = HEIGHT / 2;
	localparam bit ODD_W  = (WIDTH % 2) != 0;
	localparam bit ODD_H  = (HEIGHT % 2) != 0;

	// cosine register comes out of reset holding one in Q1.14
	localparam logic signed [irn_pkg::CFG_W-1:0] COS_RESET = 16'sd16384;

	localparam logic signed [ACC_W-1:0] OFS_X = ACC_W'(WIDTH) <<< FRAC_BITS;
	localparam logic signed [ACC_W-1:0] OFS_Y = ACC_W'(HEIGHT) <<< FRAC_BITS;

	logic signed [irn_pkg::CFG_W-1:0]   cos_q, sin_q;
	logic [irn_pkg::COORD_W-1:0]        row_q, col_q;
	logic signed [CW-1:0]               dx, dy, xs, ys;
	logic signed [PW-1:0]               p_cx_q, p_sy_q, p_cy_q, p_sx_q;
	logic signed [ACC_W-1:0]            acc_x, acc_y, src_x, src_y;
	logic                               ok_x, ok_y;
	logic                               range_q;
	logic [irn_pkg::ADDR_W-1:0]         rd_addr_q;
	logic [irn_pkg::ADDR_W-1:0]         ram_addr;
	logic                               ram_we;
	logic [irn_pkg::PIX_W-1:0]          ram_rdata;
	logic [irn_pkg::COORD_W-1:0]        out_row_q, out_col_q;
	logic [irn_pkg::PIX_W-1:0]          pix_out_q;
	logic                               in_range_q;

	// angle registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cos_q <= COS_RESET;
			sin_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				irn_pkg::REG_COS: cos_q <= cfg_data;
				irn_pkg::REG_SIN: sin_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// fetch coordinates
	always_ff @(posedge clk) begin
		if (ctl.take) begin
			row_q <= row;
			col_q <= col;
		end
	end

	// centred coordinates, odd sizes truncate toward zero
	always_comb begin
		dx = $signed(CW'(col_q)) - $signed(CW'(HALF_W));
		dy = $signed(CW'(row_q)) - $signed(CW'(HALF_H));
		xs = (ODD_W && (dx > 0)) ? dx - CW'(1) : dx;
		ys = (ODD_H && (dy > 0)) ? dy - CW'(1) : dy;
	end

	// rotation products
	always_ff @(posedge clk) begin
		if (ctl.mul_en) begin
			p_cx_q <= PW'(cos_q) * PW'(xs);
			p_sy_q <= PW'(sin_q) * PW'(ys);
			p_cy_q <= PW'(cos_q) * PW'(ys);
			p_sx_q <= PW'(sin_q) * PW'(xs);
		end
	end

	// sum, floor shift and bounds check
	always_comb begin
		acc_x = ((ACC_W'(p_cx_q) + ACC_W'(p_sy_q)) <<< 1) + OFS_X;
		acc_y = ((ACC_W'(p_cy_q) - ACC_W'(p_sx_q)) <<< 1) + OFS_Y;
		src_x = acc_x >>> (FRAC_BITS + 1);
		src_y = acc_y >>> (FRAC_BITS + 1);
		ok_x  = !src_x[ACC_W-1] && (src_x < $signed(ACC_W'(EFF_W)));
		ok_y  = !src_y[ACC_W-1] && (src_y < $signed(ACC_W'(EFF_H)));
	end

	always_ff @(posedge clk) begin
		if (ctl.sum_en) begin
			range_q   <= ok_x && ok_y;
			rd_addr_q <= {src_y[irn_pkg::COORD_W-1:0], src_x[irn_pkg::COORD_W-1:0]};
		end
	end

	// frame store, loads outside the frame are dropped
	assign ram_we   = ctl.load_we && (9'(row) < 9'(EFF_H)) && (9'(col) < 9'(EFF_W));
	assign ram_addr = ctl.rd_en ? rd_addr_q : {row, col};

	irn_ram #(
		.DATA_W (irn_pkg::PIX_W),
		.DEPTH  (irn_pkg::STORE_DIM * irn_pkg::STORE_DIM)
	) u_frame (
		.clk   (clk),
		.we    (ram_we),
		.re    (ctl.rd_en),
		.addr  (ram_addr),
		.wdata (pixel_in),
		.rdata (ram_rdata)
	);

	// output word register
	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			out_row_q  <= row_q;
			out_col_q  <= col_q;
			pix_out_q  <= range_q ? ram_rdata : '0;
			in_range_q <= range_q;
		end
	end

	assign out_row   = out_row_q;
	assign out_col   = out_col_q;
	assign pixel_out = pix_out_q;
	assign in_range  = in_range_q;

endmodule
